>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the receiver core; empty when SYNTH
// is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/crfr_pkg.sv
// ---------------------------------------------------------------------------
// crfr_pkg
// Types, codes and the CRC-16/CCITT-FALSE byte update shared by the frame
// receiver modules.
// ---------------------------------------------------------------------------
package crfr_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0]  START_BYTE_RESET = 8'hAA;
    localparam logic [15:0] MAX_LEN_RESET    = 16'd256;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'h1021;

    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_MAX_LEN    = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
    localparam logic [1:0] STATUS_CRC_BAD  = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_HI  = 3'd5,
        PH_CRC_LO  = 3'd6
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
        logic [1:0]  frame_status;
    } result_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> design/crfr_parser.sv
// ---------------------------------------------------------------------------
// crfr_parser
// Front part: walks the frame format one byte per beat, runs both CRCs and
// produces at most one result beat per received byte.
// ---------------------------------------------------------------------------
module crfr_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               beat_valid,
    input  logic [7:0]         beat_byte,
    input  logic [7:0]         start_byte,
    input  logic [15:0]        max_len,
    output logic               res_valid,
    output crfr_pkg::result_t  res
);

    crfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] hdr_crc_reg, hdr_crc_next;
    logic [15:0] pay_crc_reg, pay_crc_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;
    logic [15:0] len_full;
    logic [15:0] count_inc;
    logic [15:0] recv_crc;

    assign len_full  = {length_reg[15:8], beat_byte};
    assign count_inc = count_reg + 16'd1;
    assign recv_crc  = {crc_hi_reg, beat_byte};

    always_comb
    begin
        phase_next   = phase_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        hdr_crc_next = hdr_crc_reg;
        pay_crc_next = pay_crc_reg;
        crc_hi_next  = crc_hi_reg;
        res_valid    = 1'b0;
        res.kind         = crfr_pkg::KIND_PAYLOAD;
        res.payload_byte = 8'h00;
        res.frame_type   = type_reg;
        res.frame_length = length_reg;
        res.frame_status = crfr_pkg::STATUS_OK;

        if (beat_valid)
        begin
            unique case (phase_reg)
                crfr_pkg::PH_TYPE:
                begin
                    type_next    = beat_byte;
                    hdr_crc_next = crfr_pkg::crc16_update(hdr_crc_reg, beat_byte);
                    phase_next   = crfr_pkg::PH_LEN_HI;
                end
                crfr_pkg::PH_LEN_HI:
                begin
                    length_next  = {beat_byte, 8'h00};
                    hdr_crc_next = crfr_pkg::crc16_update(hdr_crc_reg, beat_byte);
                    phase_next   = crfr_pkg::PH_LEN_LO;
                end
                crfr_pkg::PH_LEN_LO:
                begin
                    length_next  = len_full;
                    hdr_crc_next = crfr_pkg::crc16_update(hdr_crc_reg, beat_byte);
                    if (len_full > max_len)
                    begin
                        phase_next       = crfr_pkg::PH_HUNT;
                        res_valid        = 1'b1;
                        res.kind         = crfr_pkg::KIND_REPORT;
                        res.frame_length = len_full;
                        res.frame_status = crfr_pkg::STATUS_TOO_LONG;
                    end
                    else if (len_full == 16'd0)
                    begin
                        phase_next = crfr_pkg::PH_CRC_HI;
                    end
                    else
                    begin
                        phase_next = crfr_pkg::PH_PAYLOAD;
                    end
                end
                crfr_pkg::PH_PAYLOAD:
                begin
                    pay_crc_next = crfr_pkg::crc16_update(pay_crc_reg, beat_byte);
                    count_next   = count_inc;
                    if (count_inc >= length_reg)
                    begin
                        phase_next = crfr_pkg::PH_CRC_HI;
                    end
                    res_valid        = 1'b1;
                    res.payload_byte = beat_byte;
                end
                crfr_pkg::PH_CRC_HI:
                begin
                    crc_hi_next = beat_byte;
                    phase_next  = crfr_pkg::PH_CRC_LO;
                end
                crfr_pkg::PH_CRC_LO:
                begin
                    phase_next = crfr_pkg::PH_HUNT;
                    res_valid  = 1'b1;
                    res.kind   = crfr_pkg::KIND_REPORT;
                    res.frame_status = ((hdr_crc_reg ^ pay_crc_reg) == recv_crc)
                                       ? crfr_pkg::STATUS_OK
                                       : crfr_pkg::STATUS_CRC_BAD;
                end
                default:
                begin
                    phase_next = crfr_pkg::PH_HUNT;
                    if (beat_byte == start_byte)
                    begin
                        hdr_crc_next = crfr_pkg::CRC_INIT;
                        pay_crc_next = crfr_pkg::CRC_INIT;
                        count_next   = 16'd0;
                        phase_next   = crfr_pkg::PH_TYPE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= crfr_pkg::PH_HUNT;
            type_reg    <= 8'h00;
            length_reg  <= 16'd0;
            count_reg   <= 16'd0;
            hdr_crc_reg <= crfr_pkg::CRC_INIT;
            pay_crc_reg <= crfr_pkg::CRC_INIT;
            crc_hi_reg  <= 8'h00;
        end
        else
        begin
            phase_reg   <= phase_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            hdr_crc_reg <= hdr_crc_next;
            pay_crc_reg <= pay_crc_next;
            crc_hi_reg  <= crc_hi_next;
        end
    end

endmodule

>>> design/crfr_fifo.sv
// ---------------------------------------------------------------------------
// crfr_fifo
// Back part: a short result queue that holds beats until the receiver pops
// them, so the parser keeps running while the output side stalls, until the queue is full.
// ---------------------------------------------------------------------------
module crfr_fifo #(
    parameter int DEPTH = crfr_pkg::FIFO_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  crfr_pkg::result_t  wr_data,
    input  logic               rd_en,
    output crfr_pkg::result_t  rd_data,
    output logic               empty,
    output logic               full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    crfr_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_wr;
    logic do_rd;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_FULL);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> design/crc_checked_frame_receiver_core.sv
// ---------------------------------------------------------------------------
// crc_checked_frame_receiver_core
// Byte-stream deframer; the frame check compares the XOR of separate
// CRC-16/CCITT-FALSE values over header and payload with the received CRC.
// ---------------------------------------------------------------------------
// Received bytes enter on push/rx_byte and are taken while full is low.
// Each payload byte leaves as a result beat (result_kind 0), and each frame
// closes with a report beat (result_kind 1) carrying type, length and status:
// ok, length above max_payload_len, or CRC mismatch.
// The parser takes one byte every cycle while full is low; its CRC update is
// a byte-parallel step, so throughput is one byte per clock while not full.
// A result beat is in the queue in the cycle after the byte that causes it,
// with empty low; it shows on the result ports once it reaches the head.
// Results wait in a FIFO_DEPTH-beat queue. When the receiver holds pop low
// the queue fills, full rises and input stops until beats are popped.
// The APB port holds start_byte at 0x0 and max_payload_len at 0x4; write
// them only while the block is idle.
// Reset empties the queue, puts the parser in start-byte hunting and loads
// start_byte 0xAA and max_payload_len 256. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module crc_checked_frame_receiver_core #(
    parameter int FIFO_DEPTH = crfr_pkg::FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  frame_type,
    output logic [15:0] frame_length,
    output logic [1:0]  frame_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]        start_byte_reg;
    logic [15:0]       max_len_reg;
    logic              cfg_wr;
    logic              accept;
    logic              res_valid;
    crfr_pkg::result_t res;
    crfr_pkg::result_t head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == crfr_pkg::REG_START_BYTE)
                    ? {24'h000000, start_byte_reg}
                    : {16'h0000, max_len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= crfr_pkg::START_BYTE_RESET;
            max_len_reg    <= crfr_pkg::MAX_LEN_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == crfr_pkg::REG_START_BYTE)
            begin
                start_byte_reg <= pwdata[7:0];
            end
            else
            begin
                max_len_reg <= pwdata[15:0];
            end
        end
    end

    assign accept = push && !full;

    crfr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (accept),
        .beat_byte  (rx_byte),
        .start_byte (start_byte_reg),
        .max_len    (max_len_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    crfr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (head),
        .empty   (empty),
        .full    (full)
    );

    assign result_kind  = head.kind;
    assign payload_byte = head.payload_byte;
    assign frame_type   = head.frame_type;
    assign frame_length = head.frame_length;
    assign frame_status = head.frame_status;

    `ASSERT_NEXT(a_result_lands, clk, rst_n, res_valid, !empty)
    `ASSERT_IMPLY(a_payload_ok, clk, rst_n, res_valid && (res.kind == crfr_pkg::KIND_PAYLOAD), res.frame_status == crfr_pkg::STATUS_OK)
    `ASSERT_IMPLY(a_too_long_len, clk, rst_n, res_valid && (res.frame_status == crfr_pkg::STATUS_TOO_LONG), res.frame_length > max_len_reg)
    `ASSERT_IMPLY(a_result_needs_byte, clk, rst_n, res_valid, accept)

endmodule
